@@ hdl/glpt_pkg.sv @@
// Shared types, register codes and elaboration-time tables for the gray-level transform.
package glpt_pkg;

    // Transform selection codes
    typedef enum logic [2:0] {
        MODE_NEG   = 3'd0,
        MODE_THR   = 3'd1,
        MODE_LOG   = 3'd2,
        MODE_GAMMA = 3'd3,
        MODE_SLICE = 3'd4
    } t_mode;

    // Register word indexes (byte address / 4)
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_SCALE  = 3'd1;
    localparam logic [2:0] REG_GEXP   = 3'd2;
    localparam logic [2:0] REG_RLOW   = 3'd3;
    localparam logic [2:0] REG_RHIGH  = 3'd4;
    localparam logic [2:0] REG_SLBIN  = 3'd5;

    localparam int GAMMA_SCALE_DEF = 100;
    localparam int DW  = 19;          // log table entry width
    localparam int TW  = DW + 10;     // exponent product / quotient width
    localparam int AW  = 19;          // scaled gamma numerator width
    localparam int NCK = 16;          // fraction bits of the exponent
    localparam logic [DW-1:0] LN_MUL = DW'(45426);

    typedef logic [DW-1:0] t_tab [256];
    typedef logic [29:0]   t_ck  [NCK];

    // Q16 base-2 log, truncated squaring per fraction bit
    function automatic logic [63:0] log2_q16(input logic [31:0] n);
        logic [63:0] ip;
        logic [63:0] m;
        logic [63:0] frac;
        ip   = '0;
        frac = '0;
        for (int i = 0; i < 31; i++) begin
            if ((n >> (i + 1)) != 0) ip = 64'(i + 1);
        end
        m = (64'(n) << 16) >> ip;
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 16;
            frac = frac << 1;
            if (m >= 64'd131072) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (n == 0) ? 64'd0 : ((ip << 16) | frac);
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_tab mk_ln_tab();
        t_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = DW'((log2_q16(32'(i + 1)) * 64'(LN_MUL)) >> 16);
        end
        return t;
    endfunction

    function automatic t_tab mk_d_tab();
        t_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = (i == 0) ? '0 : DW'(log2_q16(32'd255) - log2_q16(32'(i)));
        end
        return t;
    endfunction

    // Factor 2^(-2^-k) in Q30 for fraction bit k = 1..16
    function automatic t_ck mk_ck_tab();
        t_ck t;
        logic [63:0] ck;
        ck = isqrt64(64'd1 << 59);
        for (int k = 0; k < NCK; k++) begin
            t[k] = ck[29:0];
            ck   = isqrt64(ck << 30);
        end
        return t;
    endfunction

    localparam t_tab LN_TAB = mk_ln_tab();
    localparam t_tab D_TAB  = mk_d_tab();
    localparam t_ck  CK_TAB = mk_ck_tab();

endpackage

@@ hdl/gray_level_point_transform.sv @@
// Top level: APB registers and a 30-stage pixel transform pipeline.
// The pipe is built of the table, divide, 16 chained Q30 multiply and final divide stages.
// Throughput: one pixel per cycle; the whole pipe holds while the output beat waits.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults.
module gray_level_point_transform #(
    parameter int GAMMA_SCALE = glpt_pkg::GAMMA_SCALE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pixel_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixel_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import glpt_pkg::*;

    localparam int RW       = $clog2(GAMMA_SCALE + 1);
    localparam int ND1      = (TW + 3) / 4;
    localparam int ST_MUL1  = 1;
    localparam int ST_DIV1  = 2;
    localparam int ST_EXP   = ST_DIV1 + ND1;
    localparam int ST_SHIFT = ST_EXP + NCK;
    localparam int ST_MUL2  = ST_SHIFT + 1;
    localparam int ST_DIV2  = ST_MUL2 + 1;
    localparam int NS       = ST_DIV2 + 2;
    localparam logic [RW:0] DIVISOR = (RW + 1)'(GAMMA_SCALE);
    localparam logic [31:0] SAT_LIM = 32'(255 * GAMMA_SCALE);

    typedef struct packed {
        logic [7:0]    b3;
        logic [7:0]    y;
        logic          lg;
        logic          gam;
        logic          gz;
        logic [TW-1:0] num;
        logic [TW-1:0] quo;
        logic [RW-1:0] rem;
        logic [30:0]   r;
        logic [16:0]   p;
        logic          sat;
    } t_stage;

    logic [2:0] r_mode;
    logic [9:0] r_scale;
    logic [9:0] r_gexp;
    logic [7:0] r_rlow;
    logic [7:0] r_rhigh;
    logic       r_slbin;

    t_stage r_st [NS];
    t_stage n_st [NS];
    logic   r_vld [NS];
    logic   en;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NEG;
            r_scale <= 10'd128;
            r_gexp  <= 10'd100;
            r_rlow  <= 8'd0;
            r_rhigh <= 8'd255;
            r_slbin <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_MODE:  r_mode  <= pwdata[2:0];
                REG_SCALE: r_scale <= pwdata[9:0];
                REG_GEXP:  r_gexp  <= pwdata[9:0];
                REG_RLOW:  r_rlow  <= pwdata[7:0];
                REG_RHIGH: r_rhigh <= pwdata[7:0];
                REG_SLBIN: r_slbin <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:  prdata = {29'd0, r_mode};
            REG_SCALE: prdata = {22'd0, r_scale};
            REG_GEXP:  prdata = {22'd0, r_gexp};
            REG_RLOW:  prdata = {24'd0, r_rlow};
            REG_RHIGH: prdata = {24'd0, r_rhigh};
            REG_SLBIN: prdata = {31'd0, r_slbin};
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Advance the whole pipe unless the output beat is held
    assign en          = !r_vld[NS-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NS-1];
    assign o_pixel_out = {r_st[NS-1].b3, r_st[NS-1].y, r_st[NS-1].y, r_st[NS-1].y};

    // Entry stage: simple transforms and table lookups
    always_comb begin
        logic [7:0] x;
        x          = i_pixel_in[7:0];
        n_st[0]    = '0;
        n_st[0].b3 = i_pixel_in[31:24];
        n_st[0].gz = (x == 8'd0);
        n_st[0].lg = (r_mode == MODE_LOG);
        n_st[0].gam = (r_mode == MODE_GAMMA);
        unique case (r_mode)
            MODE_NEG:   n_st[0].y = 8'd255 - x;
            MODE_THR:   n_st[0].y = ({2'b00, x} >= r_scale) ? 8'd255 : x;
            MODE_SLICE: n_st[0].y = (x >= r_rlow && x <= r_rhigh) ?
                                    (r_slbin ? 8'd255 : x) : 8'd0;
            default:    n_st[0].y = x;
        endcase
        n_st[0].num = (r_mode == MODE_GAMMA) ? TW'(D_TAB[x]) : TW'(LN_TAB[x]);
    end

    // Later stages, each keyed by its place in the pipe
    for (genvar k = 1; k < NS; k++) begin : g_stage
        always_comb begin
            logic [TW-1:0] prod1;
            logic [60:0]   prod_r;
            logic [34:0]   prod2;
            logic [17:0]   cw;
            logic [RW:0]   tmp;
            logic [12:0]   ip;
            int            bi;
            n_st[k] = r_st[k-1];
            prod1   = '0;
            prod_r  = '0;
            prod2   = '0;
            cw      = '0;
            tmp     = '0;
            ip      = '0;
            bi      = 0;
            if (k == ST_MUL1) begin
                // Log product and exponent product
                prod1 = TW'(r_scale) * r_st[k-1].num;
                if (r_st[k-1].lg) n_st[k].y = prod1[23:16];
                n_st[k].num = TW'(r_gexp) * TW'(r_st[k-1].num[DW-1:0]);
                n_st[k].rem = '0;
                n_st[k].quo = '0;
            end else if (k >= ST_DIV1 && k < ST_EXP) begin
                // Four quotient bits of t = d*g / GAMMA_SCALE
                for (int j = 0; j < 4; j++) begin
                    bi = TW - 1 - 4 * (k - ST_DIV1) - j;
                    if (bi >= 0) begin
                        tmp = {n_st[k].rem, n_st[k].num[bi]};
                        n_st[k].quo[bi] = (tmp >= DIVISOR);
                        if (tmp >= DIVISOR) tmp = tmp - DIVISOR;
                        n_st[k].rem = tmp[RW-1:0];
                    end
                end
                if (k == ST_EXP - 1) n_st[k].r = 31'd1 << 30;
            end else if (k >= ST_EXP && k < ST_SHIFT) begin
                // Apply the factor for one fraction bit of t
                prod_r = 61'(r_st[k-1].r) *
                         61'(CK_TAB[(k >= ST_EXP && k < ST_SHIFT) ? k - ST_EXP : 0]);
                if (r_st[k-1].quo[(k >= ST_EXP && k < ST_SHIFT) ?
                                  NCK - 1 - (k - ST_EXP) : 0])
                    n_st[k].r = prod_r[60:30];
            end else if (k == ST_SHIFT) begin
                // Integer part of t, then reduce to Q16
                ip = r_st[k-1].quo[TW-1:16];
                n_st[k].p = (ip >= 13'd40) ? 17'd0 : 17'((r_st[k-1].r >> ip) >> 14);
                if (r_st[k-1].gz) n_st[k].p = (r_gexp == 10'd0) ? 17'd65536 : 17'd0;
            end else if (k == ST_MUL2) begin
                // c*255*P, dropping the Q16 fraction
                cw    = {r_scale, 8'd0} - {8'd0, r_scale};
                prod2 = 35'(cw) * 35'(r_st[k-1].p);
                n_st[k].num = TW'(prod2[34:16]);
            end else begin
                // Divide by GAMMA_SCALE, eight quotient bits over two stages
                if (k == ST_DIV2) begin
                    n_st[k].sat = (32'(r_st[k-1].num[AW-1:0]) >= SAT_LIM);
                    n_st[k].rem = RW'(32'(r_st[k-1].num[AW-1:8]));
                end
                for (int j = 0; j < 4; j++) begin
                    bi = 7 - 4 * (k - ST_DIV2) - j;
                    tmp = {n_st[k].rem, n_st[k].num[bi]};
                    n_st[k].quo[bi] = (tmp >= DIVISOR);
                    if (tmp >= DIVISOR) tmp = tmp - DIVISOR;
                    n_st[k].rem = tmp[RW-1:0];
                end
                if (k == NS - 1 && r_st[k-1].gam)
                    n_st[k].y = n_st[k].sat ? 8'd255 : n_st[k].quo[7:0];
            end
        end
    end

    // Pipeline registers: valid bits cleared by reset, payload free
    for (genvar k = 0; k < NS; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

@@ hdl/glpt_checker.sv @@
// Port-level checker for the gray-level transform, bound to the top level.
module glpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pixel_out,
    input logic        pready
);
    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_out))
        else $error("output beat changed while stalled");

    // Drop all beats after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Replicate the level into the low three bytes
    a_replicate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_out[7:0] == o_pixel_out[15:8]) &&
                        (o_pixel_out[7:0] == o_pixel_out[23:16]))
        else $error("level bytes differ");

    // Accept input exactly when the pipe can advance
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready) && pready)
        else $error("input ready out of step with output side");
endmodule

bind gray_level_point_transform glpt_checker u_glpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pixel_out (o_pixel_out),
    .pready      (pready)
);

@@ sim/gray_level_point_transform_test.sv @@
// Self-checking testbench for the gray-level point transform: directed and random pixel beats.
module gray_level_point_transform_test;
    import glpt_pkg::*;

    localparam int          GSCALE      = GAMMA_SCALE_DEF;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          DRAIN_WAIT  = 40;
    localparam logic [2:0]  MODE_SPARE  = 3'd5;
    localparam logic [2:0]  MODE_TOP    = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_pixel_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [31:0] o_pixel_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gray_level_point_transform dut (.*);

    // Shadow copy of the register file
    logic [2:0]  cur_mode  = MODE_NEG;
    logic [9:0]  cur_scale = 10'd128;
    logic [9:0]  cur_gexp  = 10'd100;
    logic [7:0]  cur_rlow  = 8'd0;
    logic [7:0]  cur_rhigh = 8'd255;
    logic        cur_slbin = 1'b0;

    logic [31:0] expected_pixels[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Q16 log2 of n, fraction by repeated truncated squaring
    function automatic logic [63:0] lg2_q16(input logic [31:0] n);
        logic [63:0] ip;
        logic [63:0] m;
        logic [63:0] frac;
        ip   = 0;
        frac = 0;
        if (n == 0) return 64'd0;
        for (int i = 1; i < 32; i++) begin
            if ((n >> i) != 0) ip = 64'(i);
        end
        m = (64'(n) << 16) >> ip;
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 16;
            frac = frac << 1;
            if (m >= 64'd131072) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (ip << 16) | frac;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] b;
        v    = v_in;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Q16 value of 2^-t for Q16 t
    function automatic logic [63:0] pow2_neg(input logic [63:0] t);
        logic [63:0] r;
        logic [63:0] ck;
        r  = 64'd1 << 30;
        ck = int_sqrt(64'd1 << 59);
        for (int k = 1; k <= 16; k++) begin
            if (t[16-k]) r = (r * ck) >> 30;
            ck = int_sqrt(ck << 30);
        end
        if ((t >> 16) >= 40) return 64'd0;
        r = r >> (t >> 16);
        return r >> 14;
    endfunction

    function automatic logic [7:0] gamma_out(input logic [7:0] x);
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] v;
        if (x == 0) begin
            p = (cur_gexp == 0) ? 64'd65536 : 64'd0;
        end else begin
            d = lg2_q16(32'd255) - lg2_q16(32'(x));
            p = pow2_neg((d * 64'(cur_gexp)) / GSCALE);
        end
        v = (64'(cur_scale) * 64'd255 * p) / (64'(GSCALE) << 16);
        return (v >= 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [31:0] transform_pixel(input logic [31:0] w);
        logic [7:0]  x;
        logic [7:0]  y;
        logic [63:0] ln;
        logic [63:0] prod;
        x = w[7:0];
        case (cur_mode)
            MODE_NEG:   y = 8'd255 - x;
            MODE_THR:   y = (10'(x) >= cur_scale) ? 8'd255 : x;
            MODE_LOG: begin
                ln   = (lg2_q16(32'(x) + 1) * 64'd45426) >> 16;
                prod = (64'(cur_scale) * ln) >> 16;
                y    = prod[7:0];
            end
            MODE_GAMMA: y = gamma_out(x);
            MODE_SLICE: begin
                if (x >= cur_rlow && x <= cur_rhigh) y = cur_slbin ? 8'd255 : x;
                else y = 8'd0;
            end
            default:    y = x;
        endcase
        return {w[31:24], y, y, y};
    endfunction

    // Write one register over APB once the pipeline has drained
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:  cur_mode  = val[2:0];
            REG_SCALE: cur_scale = val[9:0];
            REG_GEXP:  cur_gexp  = val[9:0];
            REG_RLOW:  cur_rlow  = val[7:0];
            REG_RHIGH: cur_rhigh = val[7:0];
            REG_SLBIN: cur_slbin = val[0];
            default: ;
        endcase
    endtask

    // Send one pixel beat, with optional idle cycles ahead of it
    task automatic send_pixel(input logic [31:0] w);
        logic rdy;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= w;
        do begin
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end while (!rdy);
        expected_pixels.push_back(transform_pixel(w));
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic sweep_levels(input int step);
        for (int x = 0; x < 256; x += step) send_pixel({24'($urandom()), 8'(x)});
        send_pixel({8'hFF, 16'h0000, 8'hFF});
        end_burst();
    endtask

    task automatic test_negative();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5A00_0080);
        end_burst();
        reg_write(REG_MODE, 32'(MODE_NEG));
        sweep_levels(51);
    endtask

    task automatic test_threshold();
        reg_write(REG_MODE, 32'(MODE_THR));
        reg_write(REG_SCALE, 32'd128);
        send_pixel(32'h0100_007F);
        send_pixel(32'h0200_0080);
        end_burst();
        // level above 255 never trips
        reg_write(REG_SCALE, 32'd1023);
        send_pixel(32'hA500_00FF);
        end_burst();
        reg_write(REG_SCALE, 32'd0);
        send_pixel(32'h0000_0000);
        end_burst();
    endtask

    task automatic test_log();
        reg_write(REG_MODE, 32'(MODE_LOG));
        reg_write(REG_SCALE, 32'd46);
        sweep_levels(85);
        // large multiplier wraps the product
        reg_write(REG_SCALE, 32'd1023);
        sweep_levels(85);
    endtask

    task automatic test_gamma();
        reg_write(REG_MODE, 32'(MODE_GAMMA));
        reg_write(REG_SCALE, 32'd100);
        reg_write(REG_GEXP, 32'd0);
        sweep_levels(128);
        reg_write(REG_GEXP, 32'd1023);
        sweep_levels(128);
        reg_write(REG_SCALE, 32'd1023);
        reg_write(REG_GEXP, 32'd40);
        sweep_levels(128);
    endtask

    task automatic test_slice();
        reg_write(REG_MODE, 32'(MODE_SLICE));
        reg_write(REG_RLOW, 32'd50);
        reg_write(REG_RHIGH, 32'd200);
        reg_write(REG_SLBIN, 32'd1);
        send_pixel(32'h0000_0031);
        send_pixel(32'h0000_0032);
        send_pixel(32'h0000_00C8);
        send_pixel(32'h0000_00C9);
        end_burst();
        reg_write(REG_SLBIN, 32'd0);
        send_pixel(32'h0000_0064);
        end_burst();
        // empty window passes nothing
        reg_write(REG_RLOW, 32'd255);
        reg_write(REG_RHIGH, 32'd0);
        send_pixel(32'h0000_00FF);
        send_pixel(32'h0000_0000);
        end_burst();
    endtask

    task automatic test_spare_mode();
        reg_write(REG_MODE, 32'(MODE_SPARE));
        send_pixel(32'hC300_0042);
        end_burst();
        reg_write(REG_MODE, 32'(MODE_TOP));
        send_pixel(32'h3C00_00BD);
        end_burst();
    endtask

    task automatic test_random();
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 47, 0, 35};
        stall_tab = '{0, 0, 47, 35};
        for (int ph = 0; ph < 4; ph++) begin
            for (int seg = 0; seg < 8; seg++) begin
                send_idle_pct = 0;
                stall_pct     = 0;
                reg_write(REG_MODE, $urandom_range(0, 5));
                reg_write(REG_SCALE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                                 : $urandom_range(0, 300));
                reg_write(REG_GEXP, $urandom_range(0, 1023));
                reg_write(REG_RLOW, $urandom_range(0, 255));
                reg_write(REG_RHIGH, $urandom_range(0, 255));
                reg_write(REG_SLBIN, $urandom_range(0, 1));
                send_idle_pct = idle_tab[ph];
                stall_pct     = stall_tab[ph];
                // half of the segments run without gaps
                if (seg[0]) begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                for (int n = 0; n < 57; n++) send_pixel($urandom());
                end_burst();
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Drive the output side ready
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check each output beat against the oldest expectation
    always @(negedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat %h", o_pixel_out);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel_out mismatch: expected %h actual %h", want, o_pixel_out);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_negative();
        test_threshold();
        test_log();
        test_gamma();
        test_slice();
        test_spare_mode();
        test_random();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
